// File: rtl/core/tile_pose_from_sensor_points_top_defines.svh
// assertion macros for the tile pose block
`ifndef TILE_POSE_FROM_SENSOR_POINTS_TOP_DEFINES_SVH
`define TILE_POSE_FROM_SENSOR_POINTS_TOP_DEFINES_SVH
`ifndef SYNTH
`define TPOSE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tile pose check failed");
`define TPOSE_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("tile pose forbidden condition seen");
`else
`define TPOSE_ASSERT(label, prop)
`define TPOSE_NEVER(label, expr)
`endif
`endif

// File: rtl/core/tpose_pkg.sv
`default_nettype none
package tpose_pkg;

  localparam int MAG_W   = 30;  // magnitude bits after scaling
  localparam int PROD_W  = 60;
  localparam int SQ_W    = 64;  // sum of squares and root work width
  localparam int LEN_W   = 32;
  localparam int NUM_W   = 45;  // dividend: mag * 2^14 + len / 2
  localparam int FRAC_W  = 14;
  localparam int Q_W     = 16;
  localparam int SLOT_W  = 4;
  localparam int SLOTS   = 12;
  localparam int CNT_W   = 6;

  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [1:0] KIND_POS  = 2'd0;
  localparam logic [1:0] KIND_FWD  = 2'd1;
  localparam logic [1:0] KIND_SIDE = 2'd2;
  localparam logic [1:0] KIND_UP   = 2'd3;

  typedef logic [1:0] sensor_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT,
    ST_SCALE,
    ST_XMUL,
    ST_XACC,
    ST_SQMUL,
    ST_SQACC,
    ST_SQRT,
    ST_DIVLD,
    ST_DIV
  } state_t;

  // omitted sensor -> diagonal pair, forward pair, side pair
  localparam sensor_t PICK [0:3][0:5] = '{
    '{2'd1, 2'd2, 2'd1, 2'd3, 2'd2, 2'd3},
    '{2'd0, 2'd3, 2'd0, 2'd2, 2'd2, 2'd3},
    '{2'd0, 2'd3, 2'd1, 2'd3, 2'd0, 2'd1},
    '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1}
  };

  function automatic sensor_t pick_sensor(input sensor_t sel, input logic [2:0] j);
    sensor_t s;
    s = 2'd0;
    if (j < 3'd6) begin
      s = PICK[sel][j];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/tile_pose_from_sensor_points_top.sv
`default_nettype none
// channel | ports                                              | handshake
// in      | in_operation in_sensor_index in_coord_x/y/z        | in_valid / in_ready
// out     | out_vector_kind out_x/y/z out_degenerate out_last  | out_valid / out_ready
//
// a store item is written from idle; a compute item gives four items, held by
// output stalls: the load state reads 18 coordinates, then per unit vector come
// the square steps, a 32-step root and three divides, with no root or divide for
// a zero vector; scaling adds one step per halving; all products use one multiplier
// reset clears the sensor store to zero and returns the sequencer to idle; each
// result item waits in the output register, no new item until the last has left
`include "tile_pose_from_sensor_points_top_defines.svh"

module tile_pose_from_sensor_points_top
  import tpose_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire                           in_operation,
  input  wire        [1:0]              in_sensor_index,
  input  wire signed [COORD_WIDTH-1:0]  in_coord_x,
  input  wire signed [COORD_WIDTH-1:0]  in_coord_y,
  input  wire signed [COORD_WIDTH-1:0]  in_coord_z,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic       [1:0]              out_vector_kind,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          out_degenerate,
  output logic                          out_last
);

  // vector width: covers raw differences and the unscaled cross product
  localparam int VW = (COORD_WIDTH + 1 > 63) ? COORD_WIDTH + 1 : 63;

  state_t state_r, state_nxt;

  logic signed [COORD_WIDTH-1:0] coord_r [SLOTS];

  sensor_t            sel_r;
  logic [1:0]         axis_r;
  logic [2:0]         pick_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [1:0]         vsel_r;   // 0 forward, 1 side, 2 up
  logic signed [VW-1:0] tmp_r;
  logic signed [VW-1:0] vec_r [3][3];
  logic [PROD_W-1:0]  prod_r;
  logic               psign_r;
  logic [SQ_W-1:0]    n_r;
  logic [SQ_W-1:0]    root_r;
  logic [LEN_W-1:0]   len_r;
  logic [LEN_W-1:0]   rem_r;
  logic [NUM_W-1:0]   div_r;

  logic [1:0]                    out_kind_r;
  logic signed [COORD_WIDTH-1:0] out_c_r [3];
  logic                          out_degen_r;
  logic                          out_last_r;

  // --- store read: one coordinate per cycle during load
  logic [SLOT_W-1:0]   rd_slot;
  logic signed [VW-1:0] rd_ext;
  logic signed [VW-1:0] ld_sum;
  logic signed [VW-1:0] ld_diff;
  logic                 load_last;

  always_comb begin
    rd_slot   = SLOT_W'(pick_sensor(sel_r, pick_r)) * SLOT_W'(3) + SLOT_W'(axis_r);
    rd_ext    = VW'(coord_r[rd_slot]);
    ld_sum    = tmp_r + rd_ext;
    ld_diff   = tmp_r - rd_ext;
    load_last = (axis_r == 2'd2) && (pick_r == 3'd5);
  end

  // --- magnitudes of the working vectors
  logic [VW-1:0] cur_mag [3];
  logic [VW-1:0] fmag [3];
  logic [VW-1:0] smag [3];
  logic          big;

  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      cur_mag[i] = vec_r[vsel_r][i][VW-1] ? VW'(-vec_r[vsel_r][i]) : VW'(vec_r[vsel_r][i]);
      fmag[i]    = vec_r[0][i][VW-1] ? VW'(-vec_r[0][i]) : VW'(vec_r[0][i]);
      smag[i]    = vec_r[1][i][VW-1] ? VW'(-vec_r[1][i]) : VW'(vec_r[1][i]);
      if ((cur_mag[i] >> MAG_W) != '0) begin
        big = 1'b1;
      end
    end
  end

  // --- shared multiplier operand select
  logic [1:0]        xc;
  logic              xt;
  logic [1:0]        fi, si;
  logic [MAG_W-1:0]  mul_a, mul_b;
  logic              mul_sign;
  logic signed [VW-1:0] xterm;

  always_comb begin
    xc = cnt_r[2:1];
    xt = cnt_r[0];
    case (xc)
      2'd0:    begin fi = xt ? 2'd2 : 2'd1; si = xt ? 2'd1 : 2'd2; end
      2'd1:    begin fi = xt ? 2'd0 : 2'd2; si = xt ? 2'd2 : 2'd0; end
      default: begin fi = xt ? 2'd1 : 2'd0; si = xt ? 2'd0 : 2'd1; end
    endcase
    if (state_r == ST_XMUL) begin
      mul_a    = fmag[fi][MAG_W-1:0];
      mul_b    = smag[si][MAG_W-1:0];
      // second term of each component is subtracted
      mul_sign = vec_r[0][fi][VW-1] ^ vec_r[1][si][VW-1] ^ xt;
    end else begin
      mul_a    = cur_mag[axis_r][MAG_W-1:0];
      mul_b    = cur_mag[axis_r][MAG_W-1:0];
      mul_sign = 1'b0;
    end
    xterm = psign_r ? -VW'(prod_r) : VW'(prod_r);
  end

  // --- sum of squares, root step, divide step
  logic [SQ_W-1:0]  sq_sum;
  logic [SQ_W-1:0]  sq_bit;
  logic [SQ_W-1:0]  sq_try;
  logic             sq_ge;
  logic [SQ_W-1:0]  root_nxt;
  logic [NUM_W-1:0] numer;
  logic [LEN_W:0]   rem_s;
  logic             div_ge;
  logic [NUM_W-1:0] quo;
  logic signed [Q_W-1:0] qs;

  always_comb begin
    sq_sum   = ((axis_r == 2'd0) ? '0 : n_r) + SQ_W'(prod_r);
    sq_bit   = SQ_W'(1) << {cnt_r[4:0], 1'b0};
    sq_try   = root_r + sq_bit;
    sq_ge    = n_r >= sq_try;
    root_nxt = sq_ge ? ((root_r >> 1) + sq_bit) : (root_r >> 1);
    numer    = {NUM_W'(cur_mag[axis_r][MAG_W-1:0]) << FRAC_W} + NUM_W'(len_r >> 1);
    rem_s    = {rem_r, div_r[NUM_W-1]};
    div_ge   = rem_s >= {1'b0, len_r};
    quo      = {div_r[NUM_W-2:0], div_ge};
    qs       = vec_r[vsel_r][axis_r][VW-1] ? -Q_W'(quo) : Q_W'(quo);
  end

  // --- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_EMIT);
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_operation == OP_COMPUTE) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (load_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          case (out_kind_r)
            KIND_POS:  state_nxt = ST_SCALE;
            KIND_FWD:  state_nxt = ST_SQMUL;
            KIND_SIDE: state_nxt = ST_SCALE;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCALE: begin
        if (!big) begin
          state_nxt = (vsel_r == 2'd0) ? ST_SCALE :
                      (vsel_r == 2'd1) ? ST_XMUL  : ST_SQMUL;
        end
      end
      ST_XMUL: state_nxt = ST_XACC;
      ST_XACC: state_nxt = (cnt_r == CNT_W'(5)) ? ST_SQMUL : ST_XMUL;
      ST_SQMUL: state_nxt = ST_SQACC;
      ST_SQACC: begin
        if (axis_r != 2'd2) begin
          state_nxt = ST_SQMUL;
        end else if (sq_sum == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DIVLD;
        end
      end
      ST_DIVLD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = (axis_r == 2'd2) ? ST_EMIT : ST_DIVLD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sensor store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        coord_r[i] <= '0;
      end
    end else if (state_r == ST_IDLE && in_valid && in_operation == OP_STORE) begin
      coord_r[SLOT_W'(in_sensor_index) * SLOT_W'(3)]           <= in_coord_x;
      coord_r[SLOT_W'(in_sensor_index) * SLOT_W'(3) + SLOT_W'(1)] <= in_coord_y;
      coord_r[SLOT_W'(in_sensor_index) * SLOT_W'(3) + SLOT_W'(2)] <= in_coord_z;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        sel_r  <= in_sensor_index;
        axis_r <= 2'd0;
        pick_r <= 3'd0;
      end
      ST_LOAD: begin
        case (pick_r)
          3'd1: out_c_r[axis_r] <= COORD_WIDTH'(ld_sum >>> 1);  // floor of half
          3'd3: vec_r[0][axis_r] <= ld_diff;
          3'd5: vec_r[1][axis_r] <= ld_diff;
          default: tmp_r <= rd_ext;
        endcase
        if (pick_r == 3'd5) begin
          pick_r <= 3'd0;
          axis_r <= axis_r + 2'd1;
        end else begin
          pick_r <= pick_r + 3'd1;
        end
        if (load_last) begin
          out_kind_r  <= KIND_POS;
          out_degen_r <= 1'b0;
          out_last_r  <= 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          axis_r <= 2'd0;
          case (out_kind_r)
            KIND_POS:  vsel_r <= 2'd0;
            KIND_FWD:  vsel_r <= 2'd1;
            KIND_SIDE: vsel_r <= 2'd2;
            default:   vsel_r <= 2'd0;
          endcase
        end
      end
      ST_SCALE: begin
        if (big) begin
          // halve magnitudes, sign kept: truncation toward zero
          for (int i = 0; i < 3; i++) begin
            vec_r[vsel_r][i] <= vec_r[vsel_r][i][VW-1] ? -$signed(cur_mag[i] >> 1)
                                                     : $signed(cur_mag[i] >> 1);
          end
        end else if (vsel_r == 2'd0) begin
          vsel_r <= 2'd1;
        end else if (vsel_r == 2'd1) begin
          cnt_r <= '0;
        end else begin
          axis_r <= 2'd0;
        end
      end
      ST_XMUL: begin
        prod_r  <= PROD_W'(mul_a) * PROD_W'(mul_b);
        psign_r <= mul_sign;
      end
      ST_XACC: begin
        vec_r[2][xc] <= xt ? (vec_r[2][xc] + xterm) : xterm;
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(5)) begin
          vsel_r <= 2'd0;
          axis_r <= 2'd0;
        end
      end
      ST_SQMUL: begin
        prod_r  <= PROD_W'(mul_a) * PROD_W'(mul_b);
        psign_r <= mul_sign;
      end
      ST_SQACC: begin
        n_r <= sq_sum;
        if (axis_r != 2'd2) begin
          axis_r <= axis_r + 2'd1;
        end else begin
          axis_r <= 2'd0;
          root_r <= '0;
          cnt_r  <= CNT_W'(31);
          if (sq_sum == '0) begin
            for (int i = 0; i < 3; i++) begin
              out_c_r[i] <= '0;
            end
            out_kind_r  <= vsel_r + 2'd1;
            out_degen_r <= 1'b1;
            out_last_r  <= (vsel_r == 2'd2);
          end
        end
      end
      ST_SQRT: begin
        if (sq_ge) begin
          n_r <= n_r - sq_try;
        end
        root_r <= root_nxt;
        cnt_r  <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          len_r <= root_nxt[LEN_W-1:0];
        end
      end
      ST_DIVLD: begin
        div_r <= numer;
        rem_r <= '0;
        cnt_r <= CNT_W'(NUM_W - 1);
      end
      ST_DIV: begin
        // remainder stays below len, so it fits in LEN_W bits
        rem_r <= LEN_W'(div_ge ? (rem_s - {1'b0, len_r}) : rem_s);
        div_r <= quo;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          out_c_r[axis_r] <= COORD_WIDTH'(qs);
          axis_r <= axis_r + 2'd1;
          if (axis_r == 2'd2) begin
            out_kind_r  <= vsel_r + 2'd1;
            out_degen_r <= 1'b0;
            out_last_r  <= (vsel_r == 2'd2);
          end
        end
      end
      default: begin
        axis_r <= 2'd0;
      end
    endcase
  end

  assign out_vector_kind = out_kind_r;
  assign out_x           = out_c_r[0];
  assign out_y           = out_c_r[1];
  assign out_z           = out_c_r[2];
  assign out_degenerate  = out_degen_r;
  assign out_last        = out_last_r;

  `TPOSE_NEVER(a_no_overlap, in_ready && out_valid)
  `TPOSE_ASSERT(a_last_is_up, out_valid |-> (out_last == (out_vector_kind == KIND_UP)))
  `TPOSE_ASSERT(a_pos_clean, (out_valid && out_vector_kind == KIND_POS) |-> !out_degenerate)
  `TPOSE_ASSERT(a_len_nonzero, (state_r == ST_DIV) |-> (len_r != '0))

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import tpose_pkg::*;

  localparam int CW = 32;

  // one pending input item
  typedef struct {
    logic         op;
    logic [1:0]   sensor;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } sensor_item_t;

  // one expected pose item
  typedef struct {
    logic [1:0]    kind;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic          degen;
    logic          last;
  } pose_item_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_operation;
  logic [1:0] in_sensor_index;
  logic signed [CW-1:0] in_coord_x;
  logic signed [CW-1:0] in_coord_y;
  logic signed [CW-1:0] in_coord_z;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_vector_kind;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic signed [CW-1:0] out_z;
  logic out_degenerate;
  logic out_last;

  tile_pose_from_sensor_points_top #(.COORD_WIDTH(CW)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_sensor_index(in_sensor_index),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_vector_kind(out_vector_kind), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_degenerate(out_degenerate), .out_last(out_last)
  );

  sensor_item_t pending_items[$];
  pose_item_t   expected_poses[$];

  // predictor copy of the sensor store, indexed [sensor][axis]
  logic signed [CW-1:0] point_store [0:3][0:2];

  int  mismatch_count;
  bit  stim_done;
  bit  quiet_phase;  // stretch with no idling on either side

  // scale so every magnitude stays below 2^30, truncating toward zero
  function automatic void shrink_vec(inout longint v[3]);
    longint unsigned m[3];
    longint unsigned peak;
    int k;
    peak = 0;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      if (m[i] > peak) peak = m[i];
    end
    while ((peak >> k) >= (64'd1 << 30)) k++;
    for (int i = 0; i < 3; i++) begin
      v[i] = (v[i] < 0) ? -longint'(m[i] >> k) : longint'(m[i] >> k);
    end
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // unit vector in Q2.14; returns 1 for a zero vector
  function automatic bit unit_vec(input longint v[3], output longint u[3]);
    longint unsigned sum;
    longint unsigned len;
    longint unsigned m;
    longint unsigned q;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      sum += m * m;
    end
    if (sum == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1'b1;
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      m = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      q = (m * 64'd16384 + len / 2) / len;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic void push_pose(logic [1:0] kind, longint v[3], bit dg, bit lst);
    pose_item_t p;
    p.kind = kind;
    p.x = v[0][CW-1:0];
    p.y = v[1][CW-1:0];
    p.z = v[2][CW-1:0];
    p.degen = dg;
    p.last = lst;
    expected_poses.push_back(p);
  endfunction

  // predict the effect of one accepted item
  function automatic void predict_pose(sensor_item_t it);
    sensor_t pk[6];
    longint pos[3], fwd[3], sd[3], up[3], u[3];
    longint s;
    bit dg;
    if (it.op == OP_STORE) begin
      point_store[it.sensor][0] = it.x;
      point_store[it.sensor][1] = it.y;
      point_store[it.sensor][2] = it.z;
      return;
    end
    // pair table per omitted sensor: diagonal, forward a-b, side a-b
    case (it.sensor)
      2'd0: pk = '{2'd1, 2'd2, 2'd1, 2'd3, 2'd2, 2'd3};
      2'd1: pk = '{2'd0, 2'd3, 2'd0, 2'd2, 2'd2, 2'd3};
      2'd2: pk = '{2'd0, 2'd3, 2'd1, 2'd3, 2'd0, 2'd1};
      default: pk = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};
    endcase
    for (int i = 0; i < 3; i++) begin
      s = longint'(point_store[pk[0]][i]) + longint'(point_store[pk[1]][i]);
      pos[i] = s >>> 1;  // floor
      fwd[i] = longint'(point_store[pk[2]][i]) - longint'(point_store[pk[3]][i]);
      sd[i]  = longint'(point_store[pk[4]][i]) - longint'(point_store[pk[5]][i]);
    end
    push_pose(KIND_POS, pos, 1'b0, 1'b0);
    shrink_vec(fwd);
    shrink_vec(sd);
    up[0] = fwd[1] * sd[2] - fwd[2] * sd[1];
    up[1] = fwd[2] * sd[0] - fwd[0] * sd[2];
    up[2] = fwd[0] * sd[1] - fwd[1] * sd[0];
    dg = unit_vec(fwd, u);
    push_pose(KIND_FWD, u, dg, 1'b0);
    dg = unit_vec(sd, u);
    push_pose(KIND_SIDE, u, dg, 1'b0);
    shrink_vec(up);
    dg = unit_vec(up, u);
    push_pose(KIND_UP, u, dg, 1'b1);
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // random coordinate with a bias toward edges and small values
  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'($urandom_range(0, 200)) - 100);
      3, 4: return 32'(signed'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_item(logic op, logic [1:0] sn,
                                     logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
    sensor_item_t it;
    it.op = op; it.sensor = sn; it.x = x; it.y = y; it.z = z;
    pending_items.push_back(it);
  endfunction

  // stimulus
  initial begin
    for (int s = 0; s < 4; s++)
      for (int a = 0; a < 3; a++) point_store[s][a] = '0;
    quiet_phase = 1'b0;
    // all zero store: every direction vector degenerate
    queue_item(OP_COMPUTE, 2'd0, 32'h0, 32'h0, 32'h0);
    // a tidy unit square
    queue_item(OP_STORE, 2'd0, 32'h0, 32'h0, 32'h0);
    queue_item(OP_STORE, 2'd1, 32'h0001_0000, 32'h0, 32'h0);
    queue_item(OP_STORE, 2'd2, 32'h0, 32'h0001_0000, 32'h0);
    queue_item(OP_STORE, 2'd3, 32'h0001_0000, 32'h0001_0000, 32'h0);
    for (int s = 0; s < 4; s++) queue_item(OP_COMPUTE, 2'(s), $urandom, $urandom, $urandom);
    // extremes: wide differences force scaling, floor midpoint of odd negatives
    queue_item(OP_STORE, 2'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    queue_item(OP_STORE, 2'd1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    queue_item(OP_STORE, 2'd2, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    queue_item(OP_STORE, 2'd3, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0001);
    for (int s = 0; s < 4; s++) queue_item(OP_COMPUTE, 2'(s), 32'h0, 32'h0, 32'h0);
    // collinear points: parallel forward and side give a zero up vector
    queue_item(OP_STORE, 2'd0, 32'h0000_0000, 32'h0, 32'h0);
    queue_item(OP_STORE, 2'd1, 32'h0001_0000, 32'h0, 32'h0);
    queue_item(OP_STORE, 2'd2, 32'h0002_0000, 32'h0, 32'h0);
    queue_item(OP_STORE, 2'd3, 32'h0003_0000, 32'h0, 32'h0);
    queue_item(OP_COMPUTE, 2'd0, 32'h0, 32'h0, 32'h0);
    queue_item(OP_COMPUTE, 2'd2, 32'h0, 32'h0, 32'h0);

    // random part: mostly full sensor refreshes followed by a compute
    while (pending_items.size() < 310) begin
      if ($urandom_range(0, 3) != 0) begin
        for (int s = 0; s < 4; s++)
          if ($urandom_range(0, 4) != 0)
            queue_item(OP_STORE, 2'(s), pick_coord(), pick_coord(), pick_coord());
      end else begin
        queue_item(OP_STORE, 2'($urandom_range(0, 3)), pick_coord(), pick_coord(),
                   pick_coord());
      end
      queue_item(OP_COMPUTE, 2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
    end

    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // middle of the run goes without idling
    wait (pending_items.size() < 200);
    quiet_phase = 1'b1;
    wait (pending_items.size() < 130);
    quiet_phase = 1'b0;
  end

  // driver
  initial begin
    in_valid = 1'b0;
    in_operation = 1'b0;
    in_sensor_index = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    out_ready = 1'b0;
    stim_done = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sensor_item_t it;
        it.op = in_operation; it.sensor = in_sensor_index;
        it.x = in_coord_x; it.y = in_coord_y; it.z = in_coord_z;
        predict_pose(it);
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 6)) begin
          sensor_item_t nx;
          nx = pending_items.pop_front();
          in_valid <= 1'b1;
          in_operation <= nx.op;
          in_sensor_index <= nx.sensor;
          in_coord_x <= nx.x;
          in_coord_y <= nx.y;
          in_coord_z <= nx.z;
        end else begin
          in_valid <= 1'b0;
          if (pending_items.size() == 0) stim_done <= 1'b1;
        end
      end
      out_ready <= quiet_phase || ($urandom_range(0, 99) >= 6);
    end
  end

  // monitor: compare each result item with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_poses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected item: kind %0d x %h y %h z %h", out_vector_kind,
                   out_x, out_y, out_z);
      end else begin
        pose_item_t e;
        e = expected_poses.pop_front();
        if (e.kind !== out_vector_kind || e.x !== out_x || e.y !== out_y ||
            e.z !== out_z || e.degen !== out_degenerate || e.last !== out_last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp kind %0d %h %h %h dg %b l %b / got %0d %h %h %h dg %b l %b",
                     e.kind, e.x, e.y, e.z, e.degen, e.last, out_vector_kind,
                     out_x, out_y, out_z, out_degenerate, out_last);
        end
      end
    end
  end

  // end of run
  initial begin
    mismatch_count = 0;
    wait (stim_done && !in_valid && expected_poses.size() == 0);
    repeat (1000) @(posedge clk);
    if (mismatch_count == 0 && expected_poses.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog: fails the run if it never finishes
  initial begin
    #(12 * 3000000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
